// ----- rtl/psq_pkg.sv -----
`timescale 1ns / 1ps
// psq_pkg: shared types and constants for the per-stream send queue accounting block
// no dependencies

package psq_pkg;

  localparam int unsigned StreamsDefault = 16;
  localparam int unsigned SidW  = 62;
  localparam int unsigned LenW  = 32;
  localparam int unsigned BklW  = 33;
  localparam logic [31:0] CapReset = 32'd1048576;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_PLAN   = 2'd1,
    MODE_COMMIT = 2'd2,
    MODE_DROP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BLOCK     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // register index of queue_cap
  localparam logic [0:0] RegQueueCap = 1'b0;

  // one command word between front and back
  typedef struct packed {
    mode_e            mode;
    logic [SidW-1:0]  sid;
    logic [LenW-1:0]  len;
    logic             fin;
  } cmd_t;

  // one result word
  typedef struct packed {
    status_e          status;
    logic [LenW-1:0]  grant;
    logic             fin_now;
    logic             more;
    logic [BklW-1:0]  backlog;
    logic [BklW-1:0]  peak;
    logic [31:0]      refused;
    logic             all_empty;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_SEARCH = 2'd1,
    BK_EXEC   = 2'd2,
    BK_OUT    = 2'd3
  } bk_state_e;

endpackage

// ----- rtl/psq_front.sv -----
`timescale 1ns / 1ps
// psq_front: accepts command words and holds them in a two-entry queue
// depends on psq_pkg

module psq_front import psq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  cmd_t cmd_i,
  output logic vld_o,
  input  logic take_i,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full_o = (cnt_q == 2'd2);
  assign vld_o  = (cnt_q != 2'd0);
  assign wr     = push_i && !full_o;
  assign rd     = take_i && vld_o;
  assign cmd_o  = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= cmd_i;
  end

endmodule

// ----- rtl/psq_back.sv -----
`timescale 1ns / 1ps
// psq_back: stream table, lookup sweep, read-modify-write and result register
// depends on psq_pkg

module psq_back import psq_pkg::*; #(
  parameter int unsigned STREAMS = StreamsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  output logic        take_o,
  input  cmd_t        cmd_i,
  input  logic [31:0] cap_i,
  output logic        empty_o,
  input  logic        pop_i,
  output res_t        res_o
);

  localparam int unsigned IdxW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

  bk_state_e           st_q, st_d;
  logic [STREAMS-1:0]  valid_q;
  logic [SidW-1:0]     sid_q [STREAMS];
  logic [BklW-1:0]     rem_q [STREAMS];
  logic                tfin_q [STREAMS];
  logic [IdxW:0]       scan_q;
  logic                hit_q, free_ok_q;
  logic [IdxW-1:0]     hit_idx_q, free_idx_q;
  cmd_t                cmd_q;
  logic [BklW-1:0]     backlog_q, peak_q;
  logic [31:0]         refused_q;
  res_t                res_q;
  logic                out_vld_q;

  logic [IdxW-1:0]     sidx;
  logic [IdxW-1:0]     eidx;
  logic                ehit;
  logic [BklW-1:0]     erem;
  logic                refuse;
  logic [BklW-1:0]     cap_x, len_x, head;
  logic                out_free;

  assign sidx    = scan_q[IdxW-1:0];
  assign take_o  = (st_q == BK_IDLE) && vld_i;
  assign empty_o = !out_vld_q;
  assign res_o   = res_q;

  // result slot is free or its word leaves at this edge
  assign out_free = !out_vld_q || pop_i;

  assign eidx = hit_q ? hit_idx_q : free_idx_q;
  assign ehit = hit_q;
  assign erem = rem_q[eidx];

  // cap check against the current backlog
  assign cap_x  = {1'b0, cap_i};
  assign len_x  = {1'b0, cmd_q.len};
  assign head   = cap_x - backlog_q;
  assign refuse = (cmd_q.len != '0) && (backlog_q != '0) &&
                  ((backlog_q >= cap_x) || (len_x > head));

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE:   if (vld_i) st_d = BK_SEARCH;
      BK_SEARCH: if (scan_q == (IdxW+1)'(STREAMS - 1)) st_d = BK_EXEC;
      BK_EXEC:   if (out_free) st_d = BK_OUT;
      BK_OUT:    st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BK_IDLE;
    else         st_q <= st_d;
  end

  // control state: table valid bits, counters, scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      backlog_q  <= '0;
      peak_q     <= '0;
      refused_q  <= '0;
      scan_q     <= '0;
      hit_q      <= 1'b0;
      free_ok_q  <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (st_q == BK_OUT) out_vld_q <= 1'b1;
      else if (pop_i)     out_vld_q <= 1'b0;
      unique case (st_q)
        BK_IDLE: begin
          scan_q    <= '0;
          hit_q     <= 1'b0;
          free_ok_q <= 1'b0;
        end
        BK_SEARCH: begin
          // one table entry per cycle
          if (valid_q[sidx] && sid_q[sidx] == cmd_q.sid && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= sidx;
          end
          if (!valid_q[sidx] && !free_ok_q) begin
            free_ok_q  <= 1'b1;
            free_idx_q <= sidx;
          end
          scan_q <= scan_q + 1'b1;
        end
        BK_EXEC: begin
          // execute only once the result slot can take the new word
          if (out_free) begin
            if (cmd_q.mode == MODE_PUSH) begin
              if (cmd_q.len == '0 && !cmd_q.fin) begin
                // empty push, nothing to do
              end else if (refuse) begin
                if (refused_q != '1) refused_q <= refused_q + 1'b1;
              end else if (ehit || free_ok_q) begin
                valid_q[eidx] <= 1'b1;
                if (cmd_q.len != '0) begin
                  backlog_q <= backlog_q + len_x;
                  if (backlog_q + len_x > peak_q) peak_q <= backlog_q + len_x;
                end
              end
            end else if (ehit) begin
              if (cmd_q.mode == MODE_COMMIT) begin
                if (len_x >= erem) begin
                  valid_q[eidx] <= 1'b0;
                  backlog_q <= (backlog_q >= erem) ? backlog_q - erem : '0;
                end else begin
                  backlog_q <= (backlog_q >= len_x) ? backlog_q - len_x : '0;
                end
              end else if (cmd_q.mode == MODE_DROP) begin
                valid_q[eidx] <= 1'b0;
                backlog_q <= (backlog_q >= erem) ? backlog_q - erem : '0;
              end
            end
          end
        end
        BK_OUT: begin
        end
        default: ;
      endcase
    end
  end

  // payload: command latch, table fields, result word
  always_ff @(posedge clk_i) begin
    if (take_o) cmd_q <= cmd_i;
    if (st_q == BK_EXEC && out_free) begin
      res_q.status  <= ST_DONE;
      res_q.grant   <= '0;
      res_q.fin_now <= 1'b0;
      res_q.more    <= 1'b0;
      if (cmd_q.mode == MODE_PUSH) begin
        if (cmd_q.len == '0 && !cmd_q.fin) begin
        end else if (refuse) begin
          res_q.status <= ST_BLOCK;
        end else if (!ehit && !free_ok_q) begin
          res_q.status <= ST_FULL;
        end else begin
          if (!ehit) begin
            sid_q[eidx] <= cmd_q.sid;
            rem_q[eidx] <= len_x;
            tfin_q[eidx] <= cmd_q.fin;
          end else if (cmd_q.len == '0) begin
            tfin_q[eidx] <= 1'b1;
          end else begin
            rem_q[eidx] <= erem + len_x;
            tfin_q[eidx] <= cmd_q.fin;
          end
        end
      end else if (!ehit) begin
        res_q.status <= ST_NOT_FOUND;
      end else if (cmd_q.mode == MODE_PLAN) begin
        res_q.grant   <= (erem < len_x) ? erem[LenW-1:0] : cmd_q.len;
        res_q.fin_now <= (erem <= len_x) && tfin_q[eidx];
        res_q.more    <= (len_x < erem);
      end else if (cmd_q.mode == MODE_COMMIT) begin
        rem_q[eidx] <= (len_x >= erem) ? '0 : erem - len_x;
      end
    end
    // counters are final in the cycle after exec, when the state is out
    if (st_q == BK_OUT) begin
      res_q.backlog   <= backlog_q;
      res_q.peak      <= peak_q;
      res_q.refused   <= refused_q;
      res_q.all_empty <= (backlog_q == '0) && (valid_q == '0);
    end
  end

endmodule

// ----- rtl/per_stream_send_queue_accounting.sv -----
`timescale 1ns / 1ps
// Per-stream send queue accounting, top level.
// Input channel: push/full carry one command word (mode, stream id, length, fin).
// Result channel: empty/pop; the oldest result sits on the result ports while
// empty is low and leaves on pop.
// Configuration: APB-style port, queue_cap at address 0, pready always high.
// A two-word command queue parts the input side from the back end, so commands
// are taken while the back end works or a result waits.
// Each command passes through the back end states in order: idle takes it, search
// checks every table entry in turn for the stream id, exec executes it and writes the
// result fields, and out registers the counters and presents the result. The next
// command is taken only once the back end is idle again; the serial search sets the pace.
// After reset the table is empty, counters are zero, queue_cap is 1048576.
// When the receiver does not pop, the finished result is held and the back end
// waits before executing the next command; the command queue fills and full rises.
// Depends on psq_pkg, psq_front, psq_back.

module per_stream_send_queue_accounting import psq_pkg::*; #(
  parameter int unsigned STREAMS = StreamsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       mode_i,
  input  logic [SidW-1:0]  stream_id_i,
  input  logic [LenW-1:0]  length_i,
  input  logic             fin_i,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       status_o,
  output logic [LenW-1:0]  grant_bytes_o,
  output logic             fin_now_o,
  output logic             more_left_o,
  output logic [BklW-1:0]  backlog_bytes_o,
  output logic [BklW-1:0]  peak_backlog_o,
  output logic [31:0]      refused_count_o,
  output logic             all_empty_o
);

  logic [31:0] cap_q;
  cmd_t        cmd_in, cmd_q;
  logic        cvld, ctake;
  res_t        res;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'b00) ? cap_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapReset;
    else if (psel && penable && pwrite && paddr == 2'b00) cap_q <= pwdata;
  end

  assign cmd_in.mode = mode_e'(mode_i);
  assign cmd_in.sid  = stream_id_i;
  assign cmd_in.len  = length_i;
  assign cmd_in.fin  = fin_i;

  psq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .cmd_i  (cmd_in),
    .vld_o  (cvld),
    .take_i (ctake),
    .cmd_o  (cmd_q)
  );

  psq_back #(.STREAMS(STREAMS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (cvld),
    .take_o  (ctake),
    .cmd_i   (cmd_q),
    .cap_i   (cap_q),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res)
  );

  assign status_o        = res.status;
  assign grant_bytes_o   = res.grant;
  assign fin_now_o       = res.fin_now;
  assign more_left_o     = res.more;
  assign backlog_bytes_o = res.backlog;
  assign peak_backlog_o  = res.peak;
  assign refused_count_o = res.refused;
  assign all_empty_o     = res.all_empty;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for per_stream_send_queue_accounting
// drives push/plan/commit/drop words with bursty gaps, predicts results, checks them
// depends on psq_pkg and the rtl top level

module tb_top;
  import psq_pkg::*;

  localparam int NSTREAM = 16;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    mode_e mode;
    logic [SidW-1:0] sid;
    logic [LenW-1:0] len;
    logic fin;
  } word_t;

  typedef struct {
    status_e status;
    logic [LenW-1:0] grant;
    logic fin_now;
    logic more;
    logic [BklW-1:0] backlog;
    logic [BklW-1:0] peak;
    logic [31:0] refused;
    logic all_empty;
  } result_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic push, full, empty, pop;
  logic [1:0] mode_i;
  logic [SidW-1:0] stream_id_i;
  logic [LenW-1:0] length_i;
  logic fin_i;
  logic [1:0] status_o;
  logic [LenW-1:0] grant_bytes_o;
  logic fin_now_o, more_left_o, all_empty_o;
  logic [BklW-1:0] backlog_bytes_o, peak_backlog_o;
  logic [31:0] refused_count_o;

  per_stream_send_queue_accounting DUT (.*);

  // predictor state
  logic [31:0] cap_q;
  logic slot_used [NSTREAM];
  logic [SidW-1:0] slot_sid [NSTREAM];
  logic [BklW-1:0] slot_left [NSTREAM];
  logic slot_fin [NSTREAM];
  logic [BklW-1:0] backlog_q, peak_q;
  logic [31:0] refusals_q;

  word_t pending_words[$];
  result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  logic [SidW-1:0] sid_pool[8];

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int find_slot(input logic [SidW-1:0] sid);
    for (int i = 0; i < NSTREAM; i++)
      if (slot_used[i] && slot_sid[i] == sid) return i;
    return -1;
  endfunction

  // work out the result of one accepted word and update the predictor
  function automatic result_t account_word(input word_t w);
    result_t r;
    int e;
    logic [BklW-1:0] take;
    logic any;
    r = '{ST_DONE, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0};
    if (w.mode == MODE_PUSH) begin
      if (w.len == 0 && !w.fin) begin
        r.status = ST_DONE;
      end else if (w.len != 0 && backlog_q != 0 &&
                   (backlog_q >= {1'b0, cap_q} ||
                    {1'b0, w.len} > {1'b0, cap_q} - backlog_q)) begin
        if (refusals_q != '1) refusals_q++;
        r.status = ST_BLOCK;
      end else begin
        e = find_slot(w.sid);
        if (e < 0) begin
          for (int i = 0; i < NSTREAM; i++)
            if (!slot_used[i] && e < 0) e = i;
          if (e >= 0) begin
            slot_used[e] = 1; slot_sid[e] = w.sid; slot_left[e] = 0; slot_fin[e] = 0;
          end
        end
        if (e < 0) r.status = ST_FULL;
        else if (w.len == 0) slot_fin[e] = 1;
        else begin
          slot_left[e] = slot_left[e] + w.len;
          slot_fin[e] = w.fin;
          backlog_q = backlog_q + w.len;
          if (backlog_q > peak_q) peak_q = backlog_q;
        end
      end
    end else begin
      e = find_slot(w.sid);
      if (e < 0) r.status = ST_NOT_FOUND;
      else if (w.mode == MODE_PLAN) begin
        take = (slot_left[e] < w.len) ? slot_left[e] : w.len;
        r.grant = take[LenW-1:0];
        r.fin_now = (take == slot_left[e]) && slot_fin[e];
        r.more = take < slot_left[e];
      end else if (w.mode == MODE_COMMIT) begin
        take = (w.len < slot_left[e]) ? w.len : slot_left[e];
        slot_left[e] -= take;
        backlog_q = (backlog_q >= take) ? backlog_q - take : '0;
        if (slot_left[e] == 0) slot_used[e] = 0;
      end else begin
        backlog_q = (backlog_q >= slot_left[e]) ? backlog_q - slot_left[e] : '0;
        slot_used[e] = 0;
      end
    end
    any = 0;
    for (int i = 0; i < NSTREAM; i++) any |= slot_used[i];
    r.backlog = backlog_q;
    r.peak = peak_q;
    r.refused = refusals_q;
    r.all_empty = (backlog_q == 0) && !any;
    return r;
  endfunction

  // sender: bursts of words with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 0; mode_i <= '0; stream_id_i <= '0; length_i <= '0; fin_i <= 0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(account_word(pending_words.pop_front()));
        idle_cycles = 0;
      end
      if (push && full) begin
        // hold the current word
      end else if (pending_words.size() != 0 && gap_left == 0) begin
        push <= 1;
        mode_i <= pending_words[0].mode;
        stream_id_i <= pending_words[0].sid;
        length_i <= pending_words[0].len;
        fin_i <= pending_words[0].fin;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
        end else burst_left--;
      end else begin
        push <= 0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // receiver: stall pattern with quiet stretches
  int stall_phase = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        idle_cycles = 0;
        if (expected_results.size() == 0) begin
          report("unexpected word", 64'(status_o), 64'd0);
        end else begin
          result_t x;
          x = expected_results.pop_front();
          if (status_o != x.status)
            report("status", 64'(status_o), 64'(x.status));
          if (grant_bytes_o != x.grant)
            report("grant_bytes", 64'(grant_bytes_o), 64'(x.grant));
          if (fin_now_o != x.fin_now)
            report("fin_now", 64'(fin_now_o), 64'(x.fin_now));
          if (more_left_o != x.more)
            report("more_left", 64'(more_left_o), 64'(x.more));
          if (backlog_bytes_o != x.backlog)
            report("backlog", 64'(backlog_bytes_o), 64'(x.backlog));
          if (peak_backlog_o != x.peak)
            report("peak", 64'(peak_backlog_o), 64'(x.peak));
          if (refused_count_o != x.refused)
            report("refused", 64'(refused_count_o), 64'(x.refused));
          if (all_empty_o != x.all_empty)
            report("all_empty", 64'(all_empty_o), 64'(x.all_empty));
        end
      end
      stall_phase = (stall_phase + 1) % 400;
      if (stall_phase < 150) pop <= 1;
      else if (stall_phase < 300) pop <= ($urandom_range(0, 3) != 0);
      else pop <= ($urandom_range(0, 4) == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic add_word(input mode_e m, input logic [SidW-1:0] s,
                          input logic [LenW-1:0] l, input logic f);
    word_t w;
    w.mode = m; w.sid = s; w.len = l; w.fin = f;
    pending_words.push_back(w);
  endtask

  task automatic write_cap(input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'd0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    cap_q = v;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_results.size() != 0 || push)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [LenW-1:0] rand_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {$urandom};
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  // random phase: random push/plan/commit/drop words, mostly on pooled stream ids, with noise
  task automatic random_phase(input int n);
    logic [SidW-1:0] s;
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(0, 9) == 0) ? SidW'({$urandom, $urandom})
                                      : sid_pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_word(MODE_PUSH, s, rand_len(), 1'($urandom_range(0, 1)));
        4, 5: add_word(MODE_PLAN, s, rand_len(), 1'($urandom_range(0, 1)));
        6, 7, 8: add_word(MODE_COMMIT, s, rand_len(), 1'($urandom_range(0, 1)));
        default: add_word(MODE_DROP, s, rand_len(), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    logic [SidW-1:0] top_sid;
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    cap_q = CapReset;
    for (int i = 0; i < NSTREAM; i++) begin
      slot_used[i] = 0; slot_sid[i] = '0; slot_left[i] = '0; slot_fin[i] = 0;
    end
    backlog_q = '0; peak_q = '0; refusals_q = '0;
    for (int i = 0; i < 8; i++) sid_pool[i] = SidW'({$urandom, $urandom});
    sid_pool[0] = '0;
    sid_pool[1] = '1;
    top_sid = '1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // directed: special cases at reset cap
    add_word(MODE_PUSH, 62'd5, 32'd0, 1'b0);       // empty push
    add_word(MODE_PLAN, 62'd5, 32'd10, 1'b0);      // unknown stream
    add_word(MODE_PUSH, 62'd5, 32'd0, 1'b1);       // bare fin creates entry
    add_word(MODE_PLAN, 62'd5, 32'd10, 1'b0);
    add_word(MODE_PUSH, top_sid, '1, 1'b1);        // onto empty backlog past cap
    add_word(MODE_PUSH, 62'd5, 32'd1, 1'b0);       // refused
    add_word(MODE_PLAN, top_sid, 32'd100, 1'b0);
    add_word(MODE_PLAN, top_sid, '1, 1'b0);
    add_word(MODE_COMMIT, top_sid, 32'd7, 1'b0);
    add_word(MODE_COMMIT, top_sid, '1, 1'b0);      // over-commit frees entry
    add_word(MODE_DROP, 62'd5, 32'd0, 1'b0);
    add_word(MODE_DROP, 62'd5, 32'd0, 1'b0);
    add_word(MODE_COMMIT, 62'd9, 32'd3, 1'b0);
    for (int i = 0; i < 17; i++) add_word(MODE_PUSH, 62'(100 + i), 32'd2, 1'b1); // table full
    drain();
    for (int i = 0; i < 16; i++) add_word(MODE_DROP, 62'(100 + i), 32'd0, 1'b0);
    drain();

    // zero cap
    write_cap(32'd0);
    add_word(MODE_PUSH, 62'd1, 32'd4, 1'b0);
    add_word(MODE_PUSH, 62'd2, 32'd1, 1'b0);
    add_word(MODE_PUSH, 62'd2, 32'd0, 1'b1);
    add_word(MODE_PLAN, 62'd1, 32'd4, 1'b1);
    random_phase(150);
    drain();

    write_cap(32'hFFFF_FFFF);
    random_phase(350);
    drain();
    write_cap(32'd1);
    random_phase(150);
    drain();
    write_cap(32'd6000);
    random_phase(400);
    drain();
    write_cap({$urandom});
    random_phase(200);
    drain();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
